// ----- rtl/core/kwc_pkg.sv -----
// ----------------------------------------------------------------------------
// kwc_pkg: shared definitions for the keyword classifier
// Keyword table, byte codes of the recognized UTF-8 sequences and the
// small helper functions that look up table entries and accented letters.
// ----------------------------------------------------------------------------
package kwc_pkg;

  // Size of the keyword table and of the packed text of one entry.
  localparam int KW_ROM_ENTRIES = 34;
  localparam int KW_TEXT_BYTES  = 16;
  localparam int KW_TEXT_W      = KW_TEXT_BYTES * 8;

  // Default configuration of the block.
  localparam int KW_NUM_DEFAULT    = 34;
  localparam int KW_MAXLEN_DEFAULT = 10;

  // Widths of the fixed fields.
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 4;
  localparam int CLASS_W = 6;

  // Saturation point of the normalized length counter.
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  // Byte codes.
  localparam logic [BYTE_W-1:0] BYTE_LEAD_2B    = 8'hC3; // accented letter lead
  localparam logic [BYTE_W-1:0] BYTE_LEAD_3B    = 8'hE2; // punctuation lead
  localparam logic [BYTE_W-1:0] BYTE_QUOTE_MID  = 8'h80; // second byte of curly quotes
  localparam logic [BYTE_W-1:0] BYTE_QUOTE_LEFT = 8'h98;
  localparam logic [BYTE_W-1:0] BYTE_QUOTE_RGHT = 8'h99;
  localparam logic [BYTE_W-1:0] BYTE_APOSTROPHE = 8'h27;
  localparam logic [BYTE_W-1:0] BYTE_BACKTICK   = 8'h60;
  localparam logic [BYTE_W-1:0] BYTE_UPPER_A    = 8'h41;
  localparam logic [BYTE_W-1:0] BYTE_UPPER_Z    = 8'h5A;
  localparam logic [BYTE_W-1:0] BYTE_CASE_BIT   = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_NONE       = 8'h00;

  // Progress through a multi-byte UTF-8 sequence.
  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_LEAD2  = 2'd1,
    PEND_LEAD3  = 2'd2,
    PEND_QUOTE  = 2'd3
  } pend_t;

  // Keyword text, right-justified: the last letter sits in the low byte.
  localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_ROM_ENTRIES] = '{
    "qallta", "tukuya", "yatiya", "qillqa", "kasta", "machaqa", "aka",
    "jila", "sapa", "sapakasta", "jilaaka", "ukaxa", "maysatxa",
    "ukhakamaxa", "kuti", "pakhina", "sarantana", "lurawi", "kuttaya",
    "apnaq", "siqicha", "khiti", "kuna", "yaqha", "yantana", "katjana",
    "tukuyawi", "pantja", "jakhuwi", "aru", "taqa", "mapa", "chiqa", "kari"
  };

  localparam logic [LEN_W-1:0] KW_LEN [KW_ROM_ENTRIES] = '{
    4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd7, 4'd3,
    4'd4, 4'd4, 4'd9, 4'd7, 4'd5, 4'd8,
    4'd10, 4'd4, 4'd7, 4'd9, 4'd6, 4'd7,
    4'd5, 4'd7, 4'd5, 4'd4, 4'd5, 4'd7, 4'd7,
    4'd8, 4'd6, 4'd7, 4'd3, 4'd4, 4'd4, 4'd5, 4'd4
  };

  // Letter of keyword k at position pos, zero past the end of the keyword.
  function automatic logic [BYTE_W-1:0] kw_char(input int k, input logic [LEN_W-1:0] pos);
    logic [LEN_W-1:0] idx;
    logic [BYTE_W-1:0] ch;
    ch = BYTE_NONE;
    if (pos < KW_LEN[k]) begin
      idx = KW_LEN[k] - pos - 4'd1;
      ch  = KW_TEXT[k][{idx, 3'b000} +: BYTE_W];
    end
    return ch;
  endfunction

  // Plain letter for the second byte of a C3 pair, zero if not a known one.
  function automatic logic [BYTE_W-1:0] accent_letter(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] ch;
    unique case (b)
      8'h9C, 8'hBC, 8'h9A, 8'hBA: ch = "u";
      8'h91, 8'hB1:               ch = "n";
      8'h81, 8'hA1:               ch = "a";
      8'h89, 8'hA9:               ch = "e";
      8'h8D, 8'hAD:               ch = "i";
      8'h93, 8'hB3:               ch = "o";
      default:                    ch = BYTE_NONE;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/core/keyword_classifier.sv -----
// ----------------------------------------------------------------------------
// keyword_classifier: byte-stream keyword recognizer
// Normalizes the bytes of one word and matches them against a fixed keyword
// table, emitting one token class per word.
// ----------------------------------------------------------------------------
//
// Usage.
// The word channel (word_valid, word_stall, word_byte, word_end) takes one raw
// byte per request; word_end marks the last byte of a word. The token channel
// (token_valid, token_stall, token_class) returns one request per word, sent
// when its last byte has been processed: 0 for an identifier, 1 to the
// number of keywords in use for a keyword in table order.
// The last byte passes through the input register and then the output register
// to token_valid. While word_stall is low the block takes one byte every cycle: each byte goes through
// an input register and one pass of compare logic across all keywords at once.
// When the receiver stalls, the finished token is held in the output register
// and later bytes of a word keep flowing; only a final byte waits in the input
// register, and then word_stall is raised until the token is taken.
// Reset empties both registers and returns the word state to its start:
// every keyword alive, length zero and no pending UTF-8 sequence.
// ----------------------------------------------------------------------------
module keyword_classifier
  import kwc_pkg::*;
#(
  parameter int NUM_KEYWORDS    = KW_NUM_DEFAULT,
  parameter int MAX_KEYWORD_LEN = KW_MAXLEN_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               word_valid,
  output logic               word_stall,
  input  logic [BYTE_W-1:0]  word_byte,
  input  logic               word_end,
  output logic               token_valid,
  input  logic               token_stall,
  output logic [CLASS_W-1:0] token_class
);

  // Only the table entries that the configuration selects take part.
  localparam int NK_USED = (NUM_KEYWORDS < KW_ROM_ENTRIES) ? NUM_KEYWORDS : KW_ROM_ENTRIES;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_KEYWORD_LEN);

  // Input register.
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_end;

  // Word state.
  pend_t              utf8_pending;
  logic [NK_USED-1:0] alive_mask;
  logic [LEN_W-1:0]   norm_length;

  // Next-state and result logic.
  pend_t              utf8_pending_next;
  logic [NK_USED-1:0] alive_mask_next;
  logic [LEN_W-1:0]   norm_length_next;
  logic [CLASS_W-1:0] class_next;
  logic [BYTE_W-1:0]  norm_char;
  logic [BYTE_W-1:0]  acc_char;
  logic               push;
  logic               fail;
  logic [NK_USED-1:0] hit;
  logic               advance;

  // A byte in the input register moves on unless it ends a word while the
  // previous token is still held by the receiver.
  assign advance    = in_valid && (!in_end || !token_valid || !token_stall);
  assign word_stall = in_valid && !advance;

  // Byte normalization and UTF-8 tracking.
  always_comb begin
    acc_char          = accent_letter(in_byte);
    norm_char         = in_byte;
    push              = 1'b0;
    fail              = 1'b0;
    utf8_pending_next = utf8_pending;
    unique case (utf8_pending)
      PEND_LEAD2: begin
        utf8_pending_next = PEND_NONE;
        if (acc_char != BYTE_NONE) begin
          push      = 1'b1;
          norm_char = acc_char;
        end else begin
          fail = 1'b1;
        end
      end
      PEND_LEAD3: begin
        if (in_byte == BYTE_QUOTE_MID) begin
          utf8_pending_next = PEND_QUOTE;
        end else begin
          fail = 1'b1;
        end
      end
      PEND_QUOTE: begin
        // Curly quotes are dropped once complete.
        if (in_byte == BYTE_QUOTE_LEFT || in_byte == BYTE_QUOTE_RGHT) begin
          utf8_pending_next = PEND_NONE;
        end else begin
          fail = 1'b1;
        end
      end
      PEND_NONE: begin
        if (!in_byte[BYTE_W-1]) begin
          if (in_byte >= BYTE_UPPER_A && in_byte <= BYTE_UPPER_Z) begin
            norm_char = in_byte | BYTE_CASE_BIT;
          end
          push = (in_byte != BYTE_APOSTROPHE) && (in_byte != BYTE_BACKTICK);
        end else if (in_byte == BYTE_LEAD_2B) begin
          utf8_pending_next = PEND_LEAD2;
        end else if (in_byte == BYTE_LEAD_3B) begin
          utf8_pending_next = PEND_LEAD3;
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
        fail = 1'b1;
      end
    endcase
    if (fail) begin
      utf8_pending_next = PEND_NONE;
    end
  end

  // Parallel compare of the normalized letter against every keyword.
  always_comb begin
    for (int k = 0; k < NK_USED; k++) begin
      hit[k] = (norm_length < MAX_LEN) && (norm_length < KW_LEN[k]) &&
               (kw_char(k, norm_length) == norm_char);
    end
    if (fail) begin
      alive_mask_next = '0;
    end else if (push) begin
      alive_mask_next = alive_mask & hit;
    end else begin
      alive_mask_next = alive_mask;
    end
    if (push && norm_length != LEN_SAT) begin
      norm_length_next = norm_length + 4'd1;
    end else begin
      norm_length_next = norm_length;
    end
  end

  // First surviving keyword whose length equals the word length wins.
  always_comb begin
    class_next = '0;
    for (int k = NK_USED - 1; k >= 0; k--) begin
      if (alive_mask_next[k] && KW_LEN[k] <= MAX_LEN && KW_LEN[k] == norm_length_next &&
          utf8_pending_next == PEND_NONE) begin
        class_next = CLASS_W'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      token_valid  <= 1'b0;
      utf8_pending <= PEND_NONE;
      alive_mask   <= '1;
      norm_length  <= '0;
    end else begin
      if (!word_stall) begin
        in_valid <= word_valid;
      end
      if (advance) begin
        if (in_end) begin
          utf8_pending <= PEND_NONE;
          alive_mask   <= '1;
          norm_length  <= '0;
        end else begin
          utf8_pending <= utf8_pending_next;
          alive_mask   <= alive_mask_next;
          norm_length  <= norm_length_next;
        end
      end
      if (advance && in_end) begin
        token_valid <= 1'b1;
      end else if (!token_stall) begin
        token_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!word_stall) begin
      in_byte <= word_byte;
      in_end  <= word_end;
    end
    if (advance && in_end) begin
      token_class <= class_next;
    end
  end

  // A stall on the word channel only ever holds a final byte.
  a_stall_only_on_end: assert property (@(posedge clk) disable iff (rst)
    word_stall |-> (in_valid && in_end && token_valid))
    else $error("word channel stalled without a held word end");

  // Once a word ends, the word state is back at its start.
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (advance && in_end) |=> (norm_length == '0 && alive_mask == '1 &&
                             utf8_pending == PEND_NONE))
    else $error("word state not cleared after the last byte");

  // A token names an identifier or an entry that is in use.
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> (token_class <= CLASS_W'(NK_USED)))
    else $error("token class beyond the keyword table");

  // A held token is not overwritten while the receiver stalls.
  a_token_hold: assert property (@(posedge clk) disable iff (rst)
    (token_valid && token_stall) |=> (token_valid && $stable(token_class)))
    else $error("stalled token changed");

endmodule
